>>> rtl/gsv_pkg.sv
// gsv_pkg: shared constants, types and lookup tables of the gaussian splat volume
// no dependencies; used by gsv_div, gsv_vol_ram and gaussian_splat_volume
package gsv_pkg;

   // volume geometry
   localparam int DIM_X      = 64;
   localparam int DIM_Y      = 64;
   localparam int DIM_Z      = 32;
   localparam int WINDOW_MAX = 15;
   localparam int VOL_SIZE   = DIM_X * DIM_Y * DIM_Z;
   localparam int ADDR_W     = (VOL_SIZE > 1) ? $clog2(VOL_SIZE) : 1;
   localparam int DIM_MAX_XY = (DIM_X > DIM_Y) ? DIM_X : DIM_Y;
   localparam int DIM_MAX    = (DIM_MAX_XY > DIM_Z) ? DIM_MAX_XY : DIM_Z;
   localparam int COORD_W    = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

   // window offsets: 0..2w with w = window / 2
   localparam int OFS_N = 2 * (WINDOW_MAX / 2) + 1;
   localparam int K_W   = (OFS_N > 1) ? $clog2(OFS_N) : 1;

   // divider widths
   localparam int DVD_W = 34;
   localparam int REM_W = 25;
   localparam int CNT_W = 6;

   // normalized distance saturation, Q.8
   localparam int T_SAT = 2048;
   localparam int T_W   = 12;
   localparam int SQ_W  = 23;

   // commands
   typedef enum logic [1:0] {
      CMD_SPLAT = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // register indexes
   localparam logic [2:0] REG_VS_X   = 3'd0;
   localparam logic [2:0] REG_VS_Y   = 3'd1;
   localparam logic [2:0] REG_VS_Z   = 3'd2;
   localparam logic [2:0] REG_ORG_X  = 3'd3;
   localparam logic [2:0] REG_ORG_Y  = 3'd4;
   localparam logic [2:0] REG_ORG_Z  = 3'd5;
   localparam logic [2:0] REG_WINDOW = 3'd6;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_C_DIV,
      ST_C_WAIT,
      ST_T_IDX,
      ST_T_DIV,
      ST_T_WAIT,
      ST_T_SQ,
      ST_T_STORE,
      ST_V_EXP,
      ST_V_WGT,
      ST_V_WR,
      ST_RD_A,
      ST_RD_B
   } state_type;

   // divider request
   typedef struct packed {
      logic              start;
      logic [REM_W-1:0]  rem_init;
      logic [DVD_W-1:0]  dvd;
      logic [CNT_W-1:0]  count;
      logic [REM_W-1:0]  den;
   } div_req_type;

   // exp(-n) in units of 2^-16, zero from n = 12 on
   function automatic logic [16:0] exp_int(input logic [7:0] n);
      logic [16:0] r;
      case (n)
         8'd0:    r = 17'd65536;
         8'd1:    r = 17'd24109;
         8'd2:    r = 17'd8869;
         8'd3:    r = 17'd3263;
         8'd4:    r = 17'd1200;
         8'd5:    r = 17'd442;
         8'd6:    r = 17'd162;
         8'd7:    r = 17'd60;
         8'd8:    r = 17'd22;
         8'd9:    r = 17'd8;
         8'd10:   r = 17'd3;
         8'd11:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // exp(-f/16) in units of 2^-16
   function automatic logic [16:0] exp_frac(input logic [3:0] f);
      logic [16:0] r;
      case (f)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd61565;
         4'd2:    r = 17'd57835;
         4'd3:    r = 17'd54331;
         4'd4:    r = 17'd51039;
         4'd5:    r = 17'd47947;
         4'd6:    r = 17'd45042;
         4'd7:    r = 17'd42313;
         4'd8:    r = 17'd39750;
         4'd9:    r = 17'd37341;
         4'd10:   r = 17'd35079;
         4'd11:   r = 17'd32954;
         4'd12:   r = 17'd30957;
         4'd13:   r = 17'd29081;
         4'd14:   r = 17'd27319;
         default: r = 17'd25664;
      endcase
      return r;
   endfunction

   // splat weight 255*256/window, Q8.8
   function automatic logic [15:0] win_weight(input logic [3:0] win);
      logic [15:0] r;
      case (win)
         4'd1:    r = 16'd65280;
         4'd2:    r = 16'd32640;
         4'd3:    r = 16'd21760;
         4'd4:    r = 16'd16320;
         4'd5:    r = 16'd13056;
         4'd6:    r = 16'd10880;
         4'd7:    r = 16'd9325;
         4'd8:    r = 16'd8160;
         4'd9:    r = 16'd7253;
         4'd10:   r = 16'd6528;
         4'd11:   r = 16'd5934;
         4'd12:   r = 16'd5440;
         4'd13:   r = 16'd5021;
         4'd14:   r = 16'd4662;
         4'd15:   r = 16'd4352;
         default: r = 16'd65280;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/gsv_div.sv
// gsv_div: restoring divider, one quotient bit per cycle
// depends on gsv_pkg (widths, div_req_type)
module gsv_div (
   input  logic                      clock,
   input  logic                      reset,
   input  gsv_pkg::div_req_type      req,
   output logic                      done,
   output logic [gsv_pkg::DVD_W-1:0] quo
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [gsv_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [gsv_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [gsv_pkg::REM_W-1:0] den_ff, den_in;
   logic [gsv_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [gsv_pkg::DVD_W-1:0] quo_ff, quo_in;
   logic [gsv_pkg::REM_W:0]   shifted;
   logic [gsv_pkg::REM_W+1:0] diff;
   logic                      ge;

   // one shift-subtract step
   always_comb begin
      shifted = {rem_ff, dvd_ff[gsv_pkg::DVD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      ge      = ~diff[gsv_pkg::REM_W+1];
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.count;
         rem_in  = req.rem_init;
         den_in  = req.den;
         dvd_in  = req.dvd;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[gsv_pkg::REM_W-1:0] : shifted[gsv_pkg::REM_W-1:0];
         dvd_in = {dvd_ff[gsv_pkg::DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[gsv_pkg::DVD_W-2:0], ge};
         cnt_in = cnt_ff - gsv_pkg::CNT_W'(1);
         if (cnt_ff == gsv_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> rtl/gsv_vol_ram.sv
// gsv_vol_ram: voxel volume memory, one write and one registered read port
// depends on gsv_pkg (VOL_SIZE, ADDR_W)
module gsv_vol_ram (
   input  logic                       clock,
   input  logic                       we,
   input  logic [gsv_pkg::ADDR_W-1:0] waddr,
   input  logic [7:0]                 wdata,
   input  logic [gsv_pkg::ADDR_W-1:0] raddr,
   output logic [7:0]                 rdata
);

   logic [7:0] mem [gsv_pkg::VOL_SIZE];
   logic [7:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/gaussian_splat_volume.sv
// gaussian_splat_volume: a read answers from the registered memory read port; clear zeroes every voxel.
// splat: 3 centre divisions, then per axis a division or a saturation per in-volume window offset
// (11-step divider), then exponent, weight and write steps per in-volume voxel.
// one item at a time: the shared divider, multiplier and the single memory set it.
// reset is synchronous; after reset a clearing pass over all VOL_SIZE (131072) voxels zeroes
// the volume before the first request is taken; registers return to their reset values.
module gaussian_splat_volume (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [23:0] req_spread_x,
   input  logic [23:0] req_spread_y,
   input  logic [23:0] req_spread_z,
   input  logic [16:0] req_voxel_index,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_voxel_value,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = gsv_pkg::ADDR_W;
   localparam int KW = gsv_pkg::K_W;
   localparam int CW = gsv_pkg::COORD_W;
   localparam int ON = gsv_pkg::OFS_N;

   // configuration registers
   logic [23:0] vs_x_ff, vs_y_ff, vs_z_ff;
   logic [31:0] org_x_ff, org_y_ff, org_z_ff;
   logic [3:0]  win_ff;

   // sequencer state
   gsv_pkg::state_type state_ff, state_in;
   logic [1:0]    axis_ff, axis_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] w_ff, w_in;
   logic [KW-1:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] vaddr_ff, vaddr_in;
   logic [gsv_pkg::T_W-1:0] q_ff, q_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_value_ff, rsp_value_in;

   // per-request payload
   logic [16:0]        idx_ff;
   logic [23:0]        sp_ff [3];
   logic signed [32:0] p_ff [3];
   logic signed [34:0] c_ff [3];
   logic               load_req;

   // per-axis tables over the window offsets
   logic [gsv_pkg::SQ_W-1:0] sq_ff [3][ON];
   logic                     ok_ff [3][ON];
   logic [CW-1:0]            coord_ff [3][ON];
   logic                     c_we, idx_we, sq_we, ok_val;
   logic [34:0]              c_val;

   // shared multiplier
   logic [23:0] mul_a;
   logic [16:0] mul_b;
   logic [40:0] prod_ff;

   // divider and memory hookup
   gsv_pkg::div_req_type div_req;
   logic                 div_done;
   logic [gsv_pkg::DVD_W-1:0] div_quo;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   // derived values
   logic [3:0]   win_eff;
   logic [15:0]  weight;
   logic [23:0]  vs_sel, sp_sel;
   logic [32:0]  p_sel, p_mag;
   logic [34:0]  c_sel;
   logic [35:0]  dim_sel, i_val, t_diff, t_mag;
   logic         i_in;
   logic [33:0]  c_num;
   logic [44:0]  t_num;
   logic         t_sat;
   logic [KW-1:0] two_w;
   logic [24:0]  sq_sum;
   logic [23:0]  a_val;
   logic [16:0]  e_val;
   logic [8:0]   v_sum;
   logic         v_ok;
   logic         t_adv, v_adv;

   gsv_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_quo)
   );

   gsv_vol_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vs_x_ff  <= 24'd2560;
         vs_y_ff  <= 24'd2560;
         vs_z_ff  <= 24'd2560;
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         win_ff   <= 4'd5;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            gsv_pkg::REG_VS_X:   vs_x_ff  <= pwdata[23:0];
            gsv_pkg::REG_VS_Y:   vs_y_ff  <= pwdata[23:0];
            gsv_pkg::REG_VS_Z:   vs_z_ff  <= pwdata[23:0];
            gsv_pkg::REG_ORG_X:  org_x_ff <= pwdata;
            gsv_pkg::REG_ORG_Y:  org_y_ff <= pwdata;
            gsv_pkg::REG_ORG_Z:  org_z_ff <= pwdata;
            gsv_pkg::REG_WINDOW: win_ff   <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (paddr[4:2])
         gsv_pkg::REG_VS_X:   prdata = {8'd0, vs_x_ff};
         gsv_pkg::REG_VS_Y:   prdata = {8'd0, vs_y_ff};
         gsv_pkg::REG_VS_Z:   prdata = {8'd0, vs_z_ff};
         gsv_pkg::REG_ORG_X:  prdata = org_x_ff;
         gsv_pkg::REG_ORG_Y:  prdata = org_y_ff;
         gsv_pkg::REG_ORG_Z:  prdata = org_z_ff;
         gsv_pkg::REG_WINDOW: prdata = {28'd0, win_ff};
         default:             prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // window width and weight
   always_comb begin
      win_eff = win_ff;
      if (win_ff == 4'd0) begin
         win_eff = 4'd1;
      end else if (32'(win_ff) > gsv_pkg::WINDOW_MAX) begin
         win_eff = 4'(gsv_pkg::WINDOW_MAX);
      end
      weight = gsv_pkg::win_weight(win_eff);
   end

   // per-axis operand selection
   always_comb begin
      case (axis_ff)
         2'd0: begin
            vs_sel  = vs_x_ff;
            dim_sel = 36'(gsv_pkg::DIM_X);
         end
         2'd1: begin
            vs_sel  = vs_y_ff;
            dim_sel = 36'(gsv_pkg::DIM_Y);
         end
         default: begin
            vs_sel  = vs_z_ff;
            dim_sel = 36'(gsv_pkg::DIM_Z);
         end
      endcase
      if (vs_sel == 24'd0) begin
         vs_sel = 24'd1;
      end
      sp_sel = sp_ff[axis_ff];
      p_sel  = p_ff[axis_ff];
      c_sel  = c_ff[axis_ff];
   end

   // centre numerator 2|p| + vs, window coordinate and distance numerator
   always_comb begin
      p_mag  = p_sel[32] ? (~p_sel + 33'd1) : p_sel;
      c_num  = {p_mag, 1'b0} + 34'(vs_sel);
      two_w  = KW'({w_ff, 1'b0});
      i_val  = {c_sel[34], c_sel} + 36'(k_ff) - 36'(w_ff);
      i_in   = !i_val[35] && (i_val < dim_sel);
      t_diff = {2'b00, prod_ff[33:0]} - {{3{p_sel[32]}}, p_sel};
      t_mag  = t_diff[35] ? (~t_diff + 36'd1) : t_diff;
      t_num  = {1'b0, t_mag[34:0], 9'd0} + 45'(sp_sel);
      t_sat  = t_num >= {9'd0, sp_sel, 12'd0};
   end

   // voxel exponent argument and address
   always_comb begin
      v_ok   = ok_ff[0][vx_ff] && ok_ff[1][vy_ff] && ok_ff[2][vz_ff];
      sq_sum = 25'(sq_ff[0][vx_ff]) + 25'(sq_ff[1][vy_ff]) + 25'(sq_ff[2][vz_ff]);
      a_val  = sq_sum[24:1];
      e_val  = 17'((prod_ff[32:0] + 33'd32768) >> 16);
      v_sum  = 9'(ram_rdata) + 9'(prod_ff[31:24]);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      clr_in       = clr_ff;
      vaddr_in     = vaddr_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      load_req     = 1'b0;
      c_we         = 1'b0;
      c_val        = '0;
      idx_we       = 1'b0;
      ok_val       = 1'b0;
      sq_we        = 1'b0;
      t_adv        = 1'b0;
      v_adv        = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;
      ram_we       = 1'b0;
      ram_waddr    = vaddr_ff;
      ram_wdata    = '0;
      ram_raddr    = vaddr_ff;
      req_ready    = 1'b0;

      case (state_ff)
         // zero the volume one voxel a cycle
         gsv_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(gsv_pkg::VOL_SIZE - 1)) begin
               state_in = gsv_pkg::ST_IDLE;
            end
         end

         // take a request
         gsv_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               load_req = 1'b1;
               axis_in  = 2'd0;
               k_in     = '0;
               w_in     = KW'(win_eff >> 1);
               clr_in   = '0;
               case (gsv_pkg::cmd_type'(req_cmd))
                  gsv_pkg::CMD_SPLAT: state_in = gsv_pkg::ST_C_DIV;
                  gsv_pkg::CMD_READ:  state_in = gsv_pkg::ST_RD_A;
                  gsv_pkg::CMD_CLEAR: state_in = gsv_pkg::ST_CLEAR;
                  default:            state_in = gsv_pkg::ST_IDLE;
               endcase
            end
         end

         // centre voxel: round(p / vs)
         gsv_pkg::ST_C_DIV: begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.dvd      = c_num;
            div_req.count    = gsv_pkg::CNT_W'(gsv_pkg::DVD_W);
            div_req.den      = {vs_sel, 1'b0};
            state_in         = gsv_pkg::ST_C_WAIT;
         end

         gsv_pkg::ST_C_WAIT: begin
            if (div_done) begin
               c_we  = 1'b1;
               c_val = p_sel[32] ? (~{1'b0, div_quo} + 35'd1) : {1'b0, div_quo};
               if (axis_ff == 2'd2) begin
                  axis_in  = 2'd0;
                  k_in     = '0;
                  state_in = gsv_pkg::ST_T_IDX;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = gsv_pkg::ST_C_DIV;
               end
            end
         end

         // window coordinate, range check and i * vs
         gsv_pkg::ST_T_IDX: begin
            idx_we = 1'b1;
            ok_val = i_in;
            mul_a  = vs_sel;
            mul_b  = 17'(i_val[CW-1:0]);
            if (i_in) begin
               state_in = gsv_pkg::ST_T_DIV;
            end else begin
               t_adv = 1'b1;
            end
         end

         // normalized distance: saturate or divide
         gsv_pkg::ST_T_DIV: begin
            if (t_sat) begin
               q_in     = gsv_pkg::T_W'(gsv_pkg::T_SAT);
               state_in = gsv_pkg::ST_T_SQ;
            end else begin
               div_req.start    = 1'b1;
               div_req.rem_init = gsv_pkg::REM_W'(t_num >> 11);
               div_req.dvd      = {t_num[10:0], 23'd0};
               div_req.count    = gsv_pkg::CNT_W'(11);
               div_req.den      = {sp_sel, 1'b0};
               state_in         = gsv_pkg::ST_T_WAIT;
            end
         end

         gsv_pkg::ST_T_WAIT: begin
            if (div_done) begin
               q_in     = div_quo[gsv_pkg::T_W-1:0];
               state_in = gsv_pkg::ST_T_SQ;
            end
         end

         gsv_pkg::ST_T_SQ: begin
            mul_a    = 24'(q_ff);
            mul_b    = 17'(q_ff);
            state_in = gsv_pkg::ST_T_STORE;
         end

         gsv_pkg::ST_T_STORE: begin
            sq_we = 1'b1;
            t_adv = 1'b1;
         end

         // voxel: exponent product and address
         gsv_pkg::ST_V_EXP: begin
            mul_a    = 24'(gsv_pkg::exp_int(a_val[23:16]));
            mul_b    = gsv_pkg::exp_frac(a_val[15:12]);
            vaddr_in = AW'(32'(coord_ff[0][vx_ff]) + 32'(gsv_pkg::DIM_X) *
                       (32'(coord_ff[1][vy_ff]) +
                        32'(gsv_pkg::DIM_Y) * 32'(coord_ff[2][vz_ff])));
            if (v_ok) begin
               state_in = gsv_pkg::ST_V_WGT;
            end else begin
               v_adv = 1'b1;
            end
         end

         gsv_pkg::ST_V_WGT: begin
            mul_a    = 24'(weight);
            mul_b    = e_val;
            state_in = gsv_pkg::ST_V_WR;
         end

         gsv_pkg::ST_V_WR: begin
            ram_we    = 1'b1;
            ram_wdata = v_sum[8] ? 8'd255 : v_sum[7:0];
            v_adv     = 1'b1;
         end

         // voxel read
         gsv_pkg::ST_RD_A: begin
            ram_raddr = AW'(idx_ff);
            state_in  = gsv_pkg::ST_RD_B;
         end

         gsv_pkg::ST_RD_B: begin
            ram_raddr = AW'(idx_ff);
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = (32'(idx_ff) < gsv_pkg::VOL_SIZE) ? ram_rdata : 8'd0;
               state_in     = gsv_pkg::ST_IDLE;
            end
         end

         default: state_in = gsv_pkg::ST_IDLE;
      endcase

      // next window offset, next axis, then the voxel walk
      if (t_adv) begin
         if (k_ff == two_w) begin
            k_in = '0;
            if (axis_ff == 2'd2) begin
               vx_in    = '0;
               vy_in    = '0;
               vz_in    = '0;
               state_in = gsv_pkg::ST_V_EXP;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = gsv_pkg::ST_T_IDX;
            end
         end else begin
            k_in     = k_ff + KW'(1);
            state_in = gsv_pkg::ST_T_IDX;
         end
      end

      // next voxel, x fastest
      if (v_adv) begin
         state_in = gsv_pkg::ST_V_EXP;
         if (vx_ff == two_w) begin
            vx_in = '0;
            if (vy_ff == two_w) begin
               vy_in = '0;
               if (vz_ff == two_w) begin
                  state_in = gsv_pkg::ST_IDLE;
               end else begin
                  vz_in = vz_ff + KW'(1);
               end
            end else begin
               vy_in = vy_ff + KW'(1);
            end
         end else begin
            vx_in = vx_ff + KW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsv_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff      <= axis_in;
      k_ff         <= k_in;
      w_ff         <= w_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      vz_ff        <= vz_in;
      vaddr_ff     <= vaddr_in;
      q_ff         <= q_in;
      rsp_value_ff <= rsp_value_in;
      prod_ff      <= 41'(mul_a) * 41'(mul_b);
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (load_req) begin
         idx_ff   <= req_voxel_index;
         sp_ff[0] <= (req_spread_x == 24'd0) ? 24'd1 : req_spread_x;
         sp_ff[1] <= (req_spread_y == 24'd0) ? 24'd1 : req_spread_y;
         sp_ff[2] <= (req_spread_z == 24'd0) ? 24'd1 : req_spread_z;
         p_ff[0]  <= $signed({req_pos_x[31], req_pos_x}) - $signed({org_x_ff[31], org_x_ff});
         p_ff[1]  <= $signed({req_pos_y[31], req_pos_y}) - $signed({org_y_ff[31], org_y_ff});
         p_ff[2]  <= $signed({req_pos_z[31], req_pos_z}) - $signed({org_z_ff[31], org_z_ff});
      end
      if (c_we) begin
         c_ff[axis_ff] <= $signed(c_val);
      end
      if (idx_we) begin
         ok_ff[axis_ff][k_ff]    <= ok_val;
         coord_ff[axis_ff][k_ff] <= i_val[CW-1:0];
      end
      if (sq_we) begin
         sq_ff[axis_ff][k_ff] <= prod_ff[gsv_pkg::SQ_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_voxel_value = rsp_value_ff;

   // divider finishes only while the sequencer waits on it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == gsv_pkg::ST_C_WAIT || state_ff == gsv_pkg::ST_T_WAIT))
      else $error("divider result outside a wait state");

   // a result only comes out of a voxel read
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == gsv_pkg::ST_RD_B))
      else $error("result raised without a voxel read");

   // splat writes stay inside the volume
   a_splat_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gsv_pkg::ST_V_WR) |-> (32'(vaddr_ff) < gsv_pkg::VOL_SIZE))
      else $error("splat write outside the volume");

endmodule
